// ===== hdl/tes_pkg.sv =====
// Shared types and constants for the timed event scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

    localparam int EVENT_SLOTS_DEF = 16;
    localparam int CYCLE_BITS_DEF  = 32;
    localparam int EVENT_ID_W      = 4;
    localparam int AMOUNT_W        = 32;
    localparam int LATE_W          = 32;
    localparam int ID_SPACE        = 1 << EVENT_ID_W;

    typedef enum logic [1:0] {
        MODE_STEP    = 2'd0,
        MODE_SCHED   = 2'd1,
        MODE_UNSCHED = 2'd2,
        MODE_DEFER   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [EVENT_ID_W-1:0] event_id;
        logic [AMOUNT_W-1:0]   amount;
    } req_t;

    typedef struct packed {
        logic [EVENT_ID_W-1:0] fired_event;
        logic [LATE_W-1:0]     lateness;
        logic                  last;
    } evt_t;

    // Commands broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic sched;
        logic unsched;
        logic eval;
        logic fire;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tes_cell.sv =====
// One event slot of the scheduler chain: armed flag, due cycle and a compare stage.
`timescale 1ns / 1ps
`default_nettype none

module tes_cell #(
    parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF,
    parameter int CYCLE_BITS  = tes_pkg::CYCLE_BITS_DEF,
    parameter int SLOT        = 0
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  tes_pkg::cell_cmd_t                  cmd,
    input  wire  [tes_pkg::EVENT_ID_W-1:0]      cmd_id,
    input  wire  [CYCLE_BITS-1:0]               due_value,
    input  wire  [CYCLE_BITS-1:0]               counter,
    input  wire  [tes_pkg::AMOUNT_W-1:0]        adv,
    input  wire  [$clog2(EVENT_SLOTS)-1:0]      fire_idx,
    input  wire                                 prev_valid,
    input  wire  [$clog2(EVENT_SLOTS)-1:0]      prev_id,
    input  wire  [CYCLE_BITS-1:0]               prev_late,
    output logic                                best_valid,
    output logic [$clog2(EVENT_SLOTS)-1:0]      best_id,
    output logic [CYCLE_BITS-1:0]               best_late
);

    localparam int IW = $clog2(EVENT_SLOTS);
    localparam int LW = (CYCLE_BITS > tes_pkg::AMOUNT_W) ? CYCLE_BITS : tes_pkg::AMOUNT_W;
    localparam bit IN_RANGE = SLOT < tes_pkg::ID_SPACE;
    localparam logic [tes_pkg::EVENT_ID_W-1:0] SLOT_ID =
        tes_pkg::EVENT_ID_W'(SLOT % tes_pkg::ID_SPACE);
    localparam logic [IW-1:0] SLOT_IDX = IW'(SLOT);

    logic                  armed_reg;
    logic                  elig_reg;
    logic [CYCLE_BITS-1:0] due_reg;
    logic [CYCLE_BITS-1:0] late_reg;
    logic [CYCLE_BITS-1:0] late_now;
    logic                  id_hit;
    logic                  fire_hit;
    logic                  fire_ok;
    logic                  take_own;

    always_comb
    begin
        id_hit   = IN_RANGE && (cmd_id == SLOT_ID);
        fire_hit = cmd.fire && (fire_idx == SLOT_IDX);
        late_now = counter - due_reg;
        fire_ok  = LW'(late_now) <= LW'(adv);
        // keep the incoming winner on ties: lower slots sit earlier in the chain
        take_own = elig_reg && (!prev_valid || (late_reg > prev_late));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            elig_reg   <= 1'b0;
            best_valid <= 1'b0;
        end
        else
        begin
            if (cmd.sched && id_hit)
                armed_reg <= 1'b1;
            else if ((cmd.unsched && id_hit) || fire_hit)
                armed_reg <= 1'b0;

            if (cmd.eval)
                elig_reg <= armed_reg && fire_ok;
            else if (fire_hit)
                elig_reg <= 1'b0;

            best_valid <= take_own || prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sched && id_hit)
            due_reg <= due_value;
        if (cmd.eval)
            late_reg <= late_now;
        if (take_own)
        begin
            best_id   <= SLOT_IDX;
            best_late <= late_reg;
        end
        else
        begin
            best_id   <= prev_id;
            best_late <= prev_late;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/timed_event_scheduler.sv =====
// Timed event scheduler top level: sequencer, cycle counter and the chain of slot cells.
//
//   channel | valid     | ready     | payload         | moves
//   --------+-----------+-----------+-----------------+-------------------------------
//   req     | req_valid | req_ready | req (req_t)     | step, schedule, unschedule, defer
//   evt     | evt_valid | evt_ready | evt (evt_t)     | one fired event
//
// Schedule, unschedule and defer are handled on acceptance and leave the sequencer idle.
// A step runs, per advance phase, an evaluation, then a scan and a pick for each fired
// event and one more: each pick waits for the winner to ripple through the
// EVENT_SLOTS-deep compare chain. A second phase runs only when a deferred advance is
// pending. Reset clears the counter, the pending advance and all armed flags. A stalled
// evt side holds the sequencer at its next pick.
`timescale 1ns / 1ps
`default_nettype none

module timed_event_scheduler #(
    parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF,
    parameter int CYCLE_BITS  = tes_pkg::CYCLE_BITS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_ready,
    input  tes_pkg::req_t  req,
    output logic           evt_valid,
    input  wire            evt_ready,
    output tes_pkg::evt_t  evt
);

    localparam int IW = $clog2(EVENT_SLOTS);
    localparam int LW = (CYCLE_BITS > tes_pkg::AMOUNT_W) ? CYCLE_BITS : tes_pkg::AMOUNT_W;
    localparam int FW = (IW > tes_pkg::EVENT_ID_W) ? IW : tes_pkg::EVENT_ID_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_PICK = 4'b1000
    } state_t;

    state_t                        state_reg,   state_next;
    logic [IW-1:0]                 cnt_reg,     cnt_next;
    logic                          phase_reg,   phase_next;
    logic [CYCLE_BITS-1:0]         counter_reg, counter_next;
    logic [tes_pkg::AMOUNT_W-1:0]  adv_reg,     adv_next;
    logic [tes_pkg::AMOUNT_W-1:0]  pending_reg, pending_next;
    logic                          hold_valid_reg, hold_valid_next;
    tes_pkg::evt_t                 hold_reg,    hold_next;
    logic                          out_valid_reg, out_valid_next;
    tes_pkg::evt_t                 out_reg,     out_next;

    tes_pkg::cell_cmd_t            cmd;
    logic [tes_pkg::AMOUNT_W-1:0]  add_amt;
    logic [CYCLE_BITS-1:0]         sum;
    logic                          req_take;
    logic                          out_free;
    logic                          proceed;

    logic                          chain_valid [EVENT_SLOTS];
    logic [IW-1:0]                 chain_id    [EVENT_SLOTS];
    logic [CYCLE_BITS-1:0]         chain_late  [EVENT_SLOTS];
    logic                          win_valid;
    logic [IW-1:0]                 win_id;
    logic [CYCLE_BITS-1:0]         win_late;
    logic [FW-1:0]                 win_id_ext;
    logic [LW-1:0]                 win_late_ext;

    assign win_valid    = chain_valid[EVENT_SLOTS-1];
    assign win_id       = chain_id[EVENT_SLOTS-1];
    assign win_late     = chain_late[EVENT_SLOTS-1];
    assign win_id_ext   = FW'(win_id);
    assign win_late_ext = LW'(win_late);

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;
    assign out_free  = !out_valid_reg || evt_ready;
    assign proceed   = !hold_valid_reg || out_free;

    // one adder serves the step advance, the due cycle and the deferred advance
    assign add_amt = (state_reg == S_IDLE) ? req.amount : pending_reg;
    assign sum     = CYCLE_BITS'(LW'(counter_reg) + LW'(add_amt));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        counter_next    = counter_reg;
        adv_next        = adv_reg;
        pending_next    = pending_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !evt_ready;
        out_next        = out_reg;
        cmd             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    case (req.mode)
                        tes_pkg::MODE_STEP:
                        begin
                            adv_next     = req.amount;
                            counter_next = sum;
                            phase_next   = 1'b0;
                            state_next   = S_EVAL;
                        end
                        tes_pkg::MODE_SCHED:   cmd.sched   = 1'b1;
                        tes_pkg::MODE_UNSCHED: cmd.unsched = 1'b1;
                        tes_pkg::MODE_DEFER:   pending_next = pending_reg + req.amount;
                        default: ;
                    endcase
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(EVENT_SLOTS - 1))
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                if (win_valid)
                begin
                    if (proceed)
                    begin
                        // release the held event: another one follows it
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                            out_next.last  = 1'b0;
                        end
                        cmd.fire              = 1'b1;
                        hold_valid_next       = 1'b1;
                        hold_next.fired_event = win_id_ext[tes_pkg::EVENT_ID_W-1:0];
                        hold_next.lateness    = win_late_ext[tes_pkg::LATE_W-1:0];
                        hold_next.last        = 1'b0;
                        cnt_next              = '0;
                        state_next            = S_SCAN;
                    end
                end
                else if (!phase_reg && (pending_reg != '0))
                begin
                    adv_next     = pending_reg;
                    counter_next = sum;
                    pending_next = '0;
                    phase_next   = 1'b1;
                    state_next   = S_EVAL;
                end
                else if (proceed)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_next.last  = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= 1'b0;
            counter_reg    <= '0;
            pending_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            counter_reg    <= counter_next;
            pending_reg    <= pending_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adv_reg  <= adv_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    for (genvar i = 0; i < EVENT_SLOTS; i++)
    begin : g_cell
        logic                  prev_valid;
        logic [IW-1:0]         prev_id;
        logic [CYCLE_BITS-1:0] prev_late;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b0;
            assign prev_id    = '0;
            assign prev_late  = '0;
        end
        else
        begin : g_link
            assign prev_valid = chain_valid[i-1];
            assign prev_id    = chain_id[i-1];
            assign prev_late  = chain_late[i-1];
        end

        tes_cell #(
            .EVENT_SLOTS (EVENT_SLOTS),
            .CYCLE_BITS  (CYCLE_BITS),
            .SLOT        (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .cmd_id     (req.event_id),
            .due_value  (sum),
            .counter    (counter_reg),
            .adv        (adv_reg),
            .fire_idx   (win_id),
            .prev_valid (prev_valid),
            .prev_id    (prev_id),
            .prev_late  (prev_late),
            .best_valid (chain_valid[i]),
            .best_id    (chain_id[i]),
            .best_late  (chain_late[i])
        );
    end

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !hold_valid_reg)
        else $error("held event left behind when the sequencer went idle");

    a_fire_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> win_valid)
        else $error("slot disarmed without a chain winner");

    a_step_evaluates: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && (req.mode == tes_pkg::MODE_STEP)) |=> (state_reg == S_EVAL))
        else $error("step item did not start an evaluation");

    a_second_phase_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg && (state_reg != S_IDLE) |-> (pending_reg == '0))
        else $error("deferred advance not cleared in second phase");

endmodule

`default_nettype wire

// ===== tb/sv/tb_timed_event_scheduler.sv =====
// Testbench for the timed event scheduler: directed and random requests, checked against a timing model.
`timescale 1ns / 1ps

module tb_timed_event_scheduler;

    localparam int          SLOTS        = tes_pkg::EVENT_SLOTS_DEF;
    localparam int          DRAIN_CYCLES = 800;
    localparam int unsigned CYCLE_LIMIT  = 1500000;
    localparam int          RANDOM_ITEMS = 330;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    tes_pkg::req_t req;
    logic evt_valid;
    logic evt_ready;
    tes_pkg::evt_t evt;

    timed_event_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timing model of the block
    logic [31:0]       now_cycle;
    logic [31:0]       deferred;
    logic              armed [SLOTS];
    logic [31:0]       due_at [SLOTS];
    tes_pkg::evt_t     pending_events [$];

    int                mismatches;
    int unsigned       cycle_count;
    int unsigned       hold_request;
    bit                tx_quiet;
    bit                rx_quiet;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Draw a wait; flip now and then between quiet stretches and random gaps.
    function automatic int unsigned pick_gap(inout bit quiet);
        if ($urandom_range(0, 29) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Advance the counter and queue every event due in the crossed window.
    function automatic void fire_window(input logic [31:0] adv);
        int            best;
        logic [31:0]   best_late;
        logic [31:0]   late;
        tes_pkg::evt_t e;
        now_cycle = now_cycle + adv;
        forever
        begin
            best = -1;
            best_late = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                late = now_cycle - due_at[i];
                if (armed[i] && late <= adv && (best < 0 || late > best_late))
                begin
                    best = i;
                    best_late = late;
                end
            end
            if (best < 0)
                break;
            armed[best] = 1'b0;
            e.fired_event = best[tes_pkg::EVENT_ID_W-1:0];
            e.lateness = best_late;
            e.last = 1'b0;
            pending_events.push_back(e);
        end
    endfunction

    function automatic void apply_request(input tes_pkg::req_t r);
        int            base_count;
        tes_pkg::evt_t e;
        base_count = pending_events.size();
        case (r.mode)
            tes_pkg::MODE_STEP:
            begin
                fire_window(r.amount);
                if (deferred != 0)
                begin
                    logic [31:0] adv;
                    adv = deferred;
                    deferred = '0;
                    fire_window(adv);
                end
                if (pending_events.size() > base_count)
                begin
                    e = pending_events.pop_back();
                    e.last = 1'b1;
                    pending_events.push_back(e);
                end
            end
            tes_pkg::MODE_SCHED:
            begin
                due_at[r.event_id] = now_cycle + r.amount;
                armed[r.event_id] = 1'b1;
            end
            tes_pkg::MODE_UNSCHED:
                armed[r.event_id] = 1'b0;
            default:
                deferred = deferred + r.amount;
        endcase
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_req(input tes_pkg::mode_t m, input logic [3:0] id,
                            input logic [31:0] amt);
        int unsigned   gap;
        tes_pkg::req_t r;
        r.mode = m;
        r.event_id = id;
        r.amount = amt;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_request(r);
    endtask

    task automatic check_event(input tes_pkg::evt_t got);
        tes_pkg::evt_t want;
        if (pending_events.size() == 0)
        begin
            report_mismatch($sformatf("event %0d lateness %0h with nothing expected",
                                      got.fired_event, got.lateness));
            return;
        end
        want = pending_events.pop_front();
        if (got.fired_event !== want.fired_event)
            report_mismatch($sformatf("fired_event got %0d expected %0d",
                                      got.fired_event, want.fired_event));
        if (got.lateness !== want.lateness)
            report_mismatch($sformatf("lateness of event %0d got %0h expected %0h",
                                      want.fired_event, got.lateness, want.lateness));
        if (got.last !== want.last)
            report_mismatch($sformatf("last of event %0d got %0b expected %0b",
                                      want.fired_event, got.last, want.last));
    endtask

    // Result side: random stalls, plus a long hold whenever one is requested.
    initial
    begin
        int unsigned stall;
        evt_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = pick_gap(rx_quiet);
            if (stall > 0)
            begin
                evt_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            evt_ready <= 1'b1;
            @(posedge clk);
            while (!evt_valid && hold_request == 0)
                @(posedge clk);
            if (evt_valid)
                check_event(evt);
        end
    end

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 8);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic test_fire_basic();
        send_req(tes_pkg::MODE_SCHED, 4'd0, 32'd5);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd5);
        // zero delay fires on a zero step
        send_req(tes_pkg::MODE_SCHED, 4'd15, 32'd0);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd0);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd0);
    endtask

    task automatic test_extremes();
        send_req(tes_pkg::MODE_SCHED, 4'd3, 32'hFFFF_FFFF);
        send_req(tes_pkg::MODE_STEP, 4'd9, 32'hFFFF_FFFE);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_rearm_unschedule();
        send_req(tes_pkg::MODE_SCHED, 4'd5, 32'd100);
        send_req(tes_pkg::MODE_SCHED, 4'd5, 32'd10);
        send_req(tes_pkg::MODE_SCHED, 4'd6, 32'd1);
        send_req(tes_pkg::MODE_UNSCHED, 4'd6, 32'd0);
        send_req(tes_pkg::MODE_UNSCHED, 4'd6, 32'hFFFF_FFFF);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd50);
    endtask

    task automatic test_deferred_advance();
        send_req(tes_pkg::MODE_SCHED, 4'd7, 32'd20);
        send_req(tes_pkg::MODE_SCHED, 4'd8, 32'd8);
        send_req(tes_pkg::MODE_SCHED, 4'd1, 32'd2);
        send_req(tes_pkg::MODE_DEFER, 4'd0, 32'd10);
        send_req(tes_pkg::MODE_DEFER, 4'd0, 32'd15);
        // first window fires slot 1, second fires 8 then 7 with last on 7
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd5);
        // pending total wraps to one
        send_req(tes_pkg::MODE_DEFER, 4'd0, 32'hFFFF_FFFF);
        send_req(tes_pkg::MODE_DEFER, 4'd0, 32'd2);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd0);
    endtask

    task automatic test_tie_order();
        send_req(tes_pkg::MODE_SCHED, 4'd9, 32'd3);
        send_req(tes_pkg::MODE_SCHED, 4'd2, 32'd3);
        send_req(tes_pkg::MODE_SCHED, 4'd12, 32'd3);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd3);
    endtask

    // Fill every slot, then hold the result side so the block backs up onto the sender.
    task automatic test_backpressure();
        for (int i = 0; i < SLOTS; i++)
            send_req(tes_pkg::MODE_SCHED, i[3:0], $urandom_range(0, 20));
        hold_request = 800;
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd30);
        send_req(tes_pkg::MODE_SCHED, 4'd4, 32'd3);
        send_req(tes_pkg::MODE_SCHED, 4'd11, 32'd1);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd5);
        send_req(tes_pkg::MODE_SCHED, 4'd13, 32'd0);
        send_req(tes_pkg::MODE_STEP, 4'd0, 32'd0);
    endtask

    // Bursts of schedules ending in a step, with some stray items mixed in.
    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_req(tes_pkg::mode_t'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)), $urandom);
                sent++;
                continue;
            end
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst; k++)
            begin
                send_req(tes_pkg::MODE_SCHED, 4'($urandom_range(0, 15)), pick_amount());
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_req(tes_pkg::MODE_UNSCHED, 4'($urandom_range(0, 15)), $urandom);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_req(tes_pkg::MODE_DEFER, 4'($urandom_range(0, 15)), pick_amount());
                sent++;
            end
            send_req(tes_pkg::MODE_STEP, 4'($urandom_range(0, 15)), pick_amount());
            sent++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        hold_request = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        now_cycle = '0;
        deferred = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            armed[i] = 1'b0;
            due_at[i] = '0;
        end
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_fire_basic();
        test_extremes();
        test_rearm_unschedule();
        test_deferred_advance();
        test_tie_order();
        test_backpressure();
        test_random_traffic();

        req_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        // let any stray result show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
